>>> design/rac_pkg.sv
// rac_pkg: shared types, constants and reset values of the radix to ascii converter
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package rac_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_DIGITS_DEF  = 32;
  localparam int MAX_RADIX       = 16;
  localparam int MIN_RADIX       = 2;

  localparam int RADIX_W  = 5;
  localparam int DIGIT_W  = 4;
  localparam int SYM_W    = 8;
  localparam int NUM_SYMS = 16;
  localparam int COUNT_W  = 6;
  localparam int CFG_W    = 32;
  localparam int CFG_IDX_W = 3;

  // quotient bits resolved per divide cycle
  localparam int DIV_STEPS = 8;

  localparam logic [RADIX_W-1:0] RADIX_RST   = 5'd10;
  localparam logic [CFG_W-1:0]   SYM_0_3_RST   = 32'h3332_3130;
  localparam logic [CFG_W-1:0]   SYM_4_7_RST   = 32'h3736_3534;
  localparam logic [CFG_W-1:0]   SYM_8_11_RST  = 32'h6261_3938;
  localparam logic [CFG_W-1:0]   SYM_12_15_RST = 32'h6665_6463;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RADIX     = 3'd0,
    REG_SYM_0_3   = 3'd1,
    REG_SYM_4_7   = 3'd2,
    REG_SYM_8_11  = 3'd3,
    REG_SYM_12_15 = 3'd4
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_SEND
  } state_t;

  typedef struct packed {
    logic [RADIX_W-1:0]                radix;
    logic [NUM_SYMS-1:0][SYM_W-1:0]    sym;
  } cfg_t;

  typedef struct packed {
    logic load;
    logic div;
    logic rd;
    logic next;
  } dp_cmd_t;

  typedef struct packed {
    logic chunk_last;
    logic quot_zero;
    logic last;
  } dp_sts_t;

endpackage

`default_nettype wire

>>> design/rac_if.sv
// rac_in_if / rac_out_if: valid-ready channels of the converter
// depends on rac_pkg
`timescale 1ns / 1ps
`default_nettype none

interface rac_in_if #(
  parameter int VALUE_WIDTH = rac_pkg::VALUE_WIDTH_DEF
);
  logic                   valid;
  logic                   ready;
  logic [VALUE_WIDTH-1:0] value;

  modport source (output valid, output value, input ready);
  modport sink   (input valid, input value, output ready);
endinterface

interface rac_out_if;
  logic                          valid;
  logic                          ready;
  logic [rac_pkg::SYM_W-1:0]     symbol;
  logic [rac_pkg::COUNT_W-1:0]   digit_count;
  logic                          last;

  modport source (output valid, output symbol, output digit_count, output last, input ready);
  modport sink   (input valid, input symbol, input digit_count, input last, output ready);
endinterface

`default_nettype wire

>>> design/rac_cfg.sv
// rac_cfg: configuration registers, radix clamp and symbol table
// depends on rac_pkg
`timescale 1ns / 1ps
`default_nettype none

module rac_cfg (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            cfg_we,
  input  wire logic [rac_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [rac_pkg::CFG_W-1:0]       cfg_wdata,
  output rac_pkg::cfg_t                        cfg
);

  logic [rac_pkg::RADIX_W-1:0] radix_r;
  logic [3:0][rac_pkg::CFG_W-1:0] sym_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r  <= rac_pkg::RADIX_RST;
      sym_r[0] <= rac_pkg::SYM_0_3_RST;
      sym_r[1] <= rac_pkg::SYM_4_7_RST;
      sym_r[2] <= rac_pkg::SYM_8_11_RST;
      sym_r[3] <= rac_pkg::SYM_12_15_RST;
    end else if (cfg_we) begin
      unique case (rac_pkg::cfg_reg_t'(cfg_index))
        rac_pkg::REG_RADIX:     radix_r  <= cfg_wdata[rac_pkg::RADIX_W-1:0];
        rac_pkg::REG_SYM_0_3:   sym_r[0] <= cfg_wdata;
        rac_pkg::REG_SYM_4_7:   sym_r[1] <= cfg_wdata;
        rac_pkg::REG_SYM_8_11:  sym_r[2] <= cfg_wdata;
        rac_pkg::REG_SYM_12_15: sym_r[3] <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (radix_r < rac_pkg::RADIX_W'(rac_pkg::MIN_RADIX)) begin
      cfg.radix = rac_pkg::RADIX_W'(rac_pkg::MIN_RADIX);
    end else if (radix_r > rac_pkg::RADIX_W'(rac_pkg::MAX_RADIX)) begin
      cfg.radix = rac_pkg::RADIX_W'(rac_pkg::MAX_RADIX);
    end else begin
      cfg.radix = radix_r;
    end
    cfg.sym = {sym_r[3], sym_r[2], sym_r[1], sym_r[0]};
  end

endmodule

`default_nettype wire

>>> design/rac_ctrl.sv
// rac_ctrl: sequencer for divide, buffer read and word emission
// depends on rac_pkg
`timescale 1ns / 1ps
`default_nettype none

module rac_ctrl (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  output logic            out_valid,
  input  wire logic       out_ready,
  input  wire rac_pkg::dp_sts_t sts,
  output rac_pkg::dp_cmd_t cmd
);

  rac_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= rac_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      rac_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = rac_pkg::ST_DIV;
      end
      rac_pkg::ST_DIV: begin
        if (sts.chunk_last && sts.quot_zero) state_nxt = rac_pkg::ST_READ;
      end
      rac_pkg::ST_READ: begin
        state_nxt = rac_pkg::ST_SEND;
      end
      rac_pkg::ST_SEND: begin
        if (out_ready) begin
          state_nxt = sts.last ? rac_pkg::ST_IDLE : rac_pkg::ST_READ;
        end
      end
      default: state_nxt = rac_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = 1'b0;
    out_valid = 1'b0;
    cmd       = '0;
    unique case (state_r)
      rac_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      rac_pkg::ST_DIV: begin
        cmd.div = 1'b1;
      end
      rac_pkg::ST_READ: begin
        cmd.rd = 1'b1;
      end
      rac_pkg::ST_SEND: begin
        out_valid = 1'b1;
        cmd.next  = out_ready && !sts.last;
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

>>> design/rac_dp.sv
// rac_dp: radix divider, digit buffer and output word register
// depends on rac_pkg
`timescale 1ns / 1ps
`default_nettype none

module rac_dp #(
  parameter int VALUE_WIDTH = rac_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = rac_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire rac_pkg::dp_cmd_t              cmd,
  output rac_pkg::dp_sts_t                   sts,
  input  wire rac_pkg::cfg_t                 cfg,
  input  wire logic [VALUE_WIDTH-1:0]        in_value,
  output logic [rac_pkg::SYM_W-1:0]          out_symbol,
  output logic [rac_pkg::COUNT_W-1:0]        out_digit_count,
  output logic                               out_last
);

  localparam int CHUNKS = (VALUE_WIDTH + rac_pkg::DIV_STEPS - 1) / rac_pkg::DIV_STEPS;
  localparam int WPAD   = CHUNKS * rac_pkg::DIV_STEPS;
  localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int NW     = $clog2(MAX_DIGITS + 1);
  localparam int AW     = $clog2(MAX_DIGITS);
  localparam int DW     = rac_pkg::DIGIT_W;

  logic [WPAD-1:0] work_r, work_step;
  logic [DW-1:0]   rem_r, rem_step;
  logic [CW-1:0]   chunk_r;
  logic [NW-1:0]   n_r;
  logic [AW-1:0]   idx_r;
  logic [DW-1:0]   rd_data_r;
  logic            last_r;
  logic            room;
  logic            finish;

  logic [DW-1:0]   digit_mem [MAX_DIGITS];

  // restoring division, one quotient bit per step
  always_comb begin
    logic [WPAD-1:0] w;
    logic [DW:0]     r;
    w = work_r;
    r = {1'b0, rem_r};
    for (int i = 0; i < rac_pkg::DIV_STEPS; i++) begin
      r = {r[DW-1:0], w[WPAD-1]};
      w = {w[WPAD-2:0], 1'b0};
      if (r >= (DW+1)'(cfg.radix)) begin
        r    = r - (DW+1)'(cfg.radix);
        w[0] = 1'b1;
      end
    end
    work_step = w;
    rem_step  = r[DW-1:0];
  end

  assign room           = n_r < NW'(MAX_DIGITS);
  assign sts.chunk_last = chunk_r == CW'(CHUNKS - 1);
  assign sts.quot_zero  = work_step == '0;
  assign sts.last       = last_r;
  assign finish         = cmd.div && sts.chunk_last && sts.quot_zero;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chunk_r <= '0;
      n_r     <= '0;
      idx_r   <= '0;
      last_r  <= 1'b0;
    end else begin
      if (cmd.load) begin
        chunk_r <= '0;
        n_r     <= '0;
      end else if (cmd.div) begin
        if (sts.chunk_last) begin
          chunk_r <= '0;
          if (room) n_r <= n_r + NW'(1);
        end else begin
          chunk_r <= chunk_r + CW'(1);
        end
      end
      if (finish) begin
        idx_r <= room ? n_r[AW-1:0] : AW'(MAX_DIGITS - 1);
      end else if (cmd.next) begin
        idx_r <= idx_r - AW'(1);
      end
      if (cmd.rd) last_r <= idx_r == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work_r <= WPAD'(in_value);
      rem_r  <= '0;
    end else if (cmd.div) begin
      work_r <= work_step;
      rem_r  <= sts.chunk_last ? '0 : rem_step;
    end
  end

  // digit buffer, least significant digit at position 0
  always_ff @(posedge clk) begin
    if (cmd.div && sts.chunk_last && room) begin
      digit_mem[n_r[AW-1:0]] <= rem_step;
    end
    if (cmd.rd) begin
      rd_data_r <= digit_mem[idx_r];
    end
  end

  assign out_symbol      = cfg.sym[rd_data_r];
  assign out_digit_count = rac_pkg::COUNT_W'(n_r);
  assign out_last        = last_r;

endmodule

`default_nettype wire

>>> design/radix_to_ascii_converter.sv
// radix_to_ascii_converter: unsigned integer to ascii digit string in radix 2 to 16
// top level; depends on rac_pkg, rac_if, rac_cfg, rac_ctrl, rac_dp
//
// usage:
//   in_ch takes one word, an unsigned value, when valid and ready are both high.
//   out_ch gives one word per digit, most significant first: the symbol from the
//   symbol table, the total digit count, and last on the final digit.
//   cfg_we/cfg_index/cfg_wdata write radix and the four symbol registers; write
//   only while the block is idle (in_ch.ready high and no word pending).
// operation:
//   each digit comes from the shared divider, which resolves 8 quotient bits a
//   cycle; then each digit takes a buffer read and then an output word.
//   one value is in work at a time.
// reset:
//   synchronous, active low; returns to idle and restores radix 10 and symbols
//   "0123456789abcdef".
// stall:
//   a word waits on out_ch with its payload held until ready; nothing is lost.
`timescale 1ns / 1ps
`default_nettype none

module radix_to_ascii_converter #(
  parameter int VALUE_WIDTH = rac_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = rac_pkg::MAX_DIGITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  rac_in_if.sink                             in_ch,
  rac_out_if.source                          out_ch,
  input  wire logic                          cfg_we,
  input  wire logic [rac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rac_pkg::CFG_W-1:0]     cfg_wdata
);

  rac_pkg::cfg_t    cfg;
  rac_pkg::dp_cmd_t cmd;
  rac_pkg::dp_sts_t sts;

  rac_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  rac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  rac_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .sts             (sts),
    .cfg             (cfg),
    .in_value        (in_ch.value),
    .out_symbol      (out_ch.symbol),
    .out_digit_count (out_ch.digit_count),
    .out_last        (out_ch.last)
  );

endmodule

`default_nettype wire

>>> dv/rac_digit_checker.sv
// rac_digit_checker: watches the value and digit channels of the converter, predicts
// every digit word and compares it field by field; depends on rac_pkg
`timescale 1ns / 1ps
`default_nettype none

module rac_digit_checker (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_ready,
  input  wire logic [31:0]                   in_value,
  input  wire logic                          out_valid,
  input  wire logic                          out_ready,
  input  wire logic [rac_pkg::SYM_W-1:0]     out_symbol,
  input  wire logic [rac_pkg::COUNT_W-1:0]   out_digit_count,
  input  wire logic                          out_last,
  input  wire logic                          cfg_we,
  input  wire logic [rac_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [rac_pkg::CFG_W-1:0]     cfg_wdata,
  output int                                 fail_count,
  output int                                 words_pending
);

  typedef struct packed {
    logic [rac_pkg::SYM_W-1:0]   symbol;
    logic [rac_pkg::COUNT_W-1:0] digit_count;
    logic                        last;
  } digit_word_t;

  logic [rac_pkg::RADIX_W-1:0]       radix_mirror;
  logic [3:0][rac_pkg::CFG_W-1:0]    sym_mirror;
  digit_word_t                       expected_digits[$];

  // repeated division, digits pushed most significant first
  function automatic void predict_digits(input logic [31:0] value);
    logic [rac_pkg::DIGIT_W-1:0] digits[rac_pkg::MAX_DIGITS_DEF];
    logic [31:0]                 base;
    logic [31:0]                 rest;
    logic [rac_pkg::DIGIT_W-1:0] d;
    digit_word_t                 w;
    int                          n;
    base = 32'(radix_mirror);
    if (base < rac_pkg::MIN_RADIX) base = rac_pkg::MIN_RADIX;
    if (base > rac_pkg::MAX_RADIX) base = rac_pkg::MAX_RADIX;
    rest = value;
    n = 0;
    do begin
      if (n < rac_pkg::MAX_DIGITS_DEF) begin
        digits[n] = rac_pkg::DIGIT_W'(rest % base);
        n++;
      end
      rest = rest / base;
    end while (rest != 0);
    for (int k = 0; k < n; k++) begin
      d = digits[n - 1 - k];
      w.symbol      = sym_mirror[d[3:2]][d[1:0]*8 +: 8];
      w.digit_count = rac_pkg::COUNT_W'(n);
      w.last        = (k == n - 1);
      expected_digits.push_back(w);
    end
  endfunction

  always @(posedge clk) begin
    digit_word_t exp_w;
    if (!rst_n) begin
      radix_mirror = rac_pkg::RADIX_RST;
      sym_mirror   = {rac_pkg::SYM_12_15_RST, rac_pkg::SYM_8_11_RST,
                      rac_pkg::SYM_4_7_RST, rac_pkg::SYM_0_3_RST};
      expected_digits.delete();
    end else begin
      if (out_valid && out_ready) begin
        if (expected_digits.size() == 0) begin
          $display("%0t ERROR unexpected word: symbol %h count %0d last %0b", $time,
                   out_symbol, out_digit_count, out_last);
          fail_count++;
        end else begin
          exp_w = expected_digits.pop_front();
          if (out_symbol !== exp_w.symbol) begin
            $display("%0t ERROR symbol: expected %h actual %h", $time,
                     exp_w.symbol, out_symbol);
            fail_count++;
          end
          if (out_digit_count !== exp_w.digit_count) begin
            $display("%0t ERROR digit_count: expected %0d actual %0d", $time,
                     exp_w.digit_count, out_digit_count);
            fail_count++;
          end
          if (out_last !== exp_w.last) begin
            $display("%0t ERROR last: expected %0b actual %0b", $time,
                     exp_w.last, out_last);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) predict_digits(in_value);
      if (cfg_we) begin
        case (cfg_index)
          rac_pkg::REG_RADIX:     radix_mirror  = cfg_wdata[rac_pkg::RADIX_W-1:0];
          rac_pkg::REG_SYM_0_3:   sym_mirror[0] = cfg_wdata;
          rac_pkg::REG_SYM_4_7:   sym_mirror[1] = cfg_wdata;
          rac_pkg::REG_SYM_8_11:  sym_mirror[2] = cfg_wdata;
          rac_pkg::REG_SYM_12_15: sym_mirror[3] = cfg_wdata;
          default: ;
        endcase
      end
    end
    words_pending = expected_digits.size();
  end

endmodule

`default_nettype wire

>>> dv/radix_to_ascii_converter_tb.sv
// radix_to_ascii_converter_tb: drives values and register writes into the converter
// and gives the verdict; depends on rac_pkg, rac_if, rac_digit_checker and the rtl
`timescale 1ns / 1ps
`default_nettype none

module radix_to_ascii_converter_tb;

  localparam int CYCLE_LIMIT = 1_000_000;
  localparam int PHASE_WORDS = 56;
  localparam logic [rac_pkg::CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  logic                          clk = 1'b0;
  logic                          rst_n;
  logic                          cfg_we;
  logic [rac_pkg::CFG_IDX_W-1:0] cfg_index;
  logic [rac_pkg::CFG_W-1:0]     cfg_wdata;
  int                            fail_count;
  int                            words_pending;
  int                            cycle_count = 0;
  bit                            idle_on;
  int                            hold_cycles;

  rac_in_if  in_ch ();
  rac_out_if out_ch ();

  radix_to_ascii_converter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  rac_digit_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_ch.valid),
    .in_ready        (in_ch.ready),
    .in_value        (in_ch.value),
    .out_valid       (out_ch.valid),
    .out_ready       (out_ch.ready),
    .out_symbol      (out_ch.symbol),
    .out_digit_count (out_ch.digit_count),
    .out_last        (out_ch.last),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .fail_count      (fail_count),
    .words_pending   (words_pending)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_value(input logic [31:0] value);
    int gap;
    gap = idle_on ? $urandom_range(0, 7) : 0;
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  task automatic write_reg(input logic [rac_pkg::CFG_IDX_W-1:0] idx,
                           input logic [rac_pkg::CFG_W-1:0] data);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (words_pending != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  function automatic logic [31:0] random_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return $urandom;
      4, 5:       return $urandom_range(0, 300);
      6:          return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0;
      default:    return $urandom >> $urandom_range(0, 31);
    endcase
  endfunction

  // receiver: random stall per word while idle_on is set, or one long hold when asked
  initial begin
    int stall;
    bit hold_taken;
    hold_taken   = 1'b0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_cycles > 0 && !hold_taken) begin
        stall = hold_cycles;
        hold_taken = 1'b1;
      end else begin
        stall = idle_on ? $urandom_range(0, 7) : 0;
      end
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!out_ch.valid);
    end
  end

  initial begin
    logic [4:0] radix_pick;
    rst_n        = 1'b0;
    in_ch.valid  = 1'b0;
    in_ch.value  = '0;
    cfg_we       = 1'b0;
    cfg_index    = rac_pkg::REG_RADIX;
    cfg_wdata    = '0;
    idle_on      = 1'b1;
    hold_cycles  = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset settings: decimal with default symbols
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'd9);
    send_value(32'd10);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);
    send_value(32'd999_999_999);
    send_value(32'd1_000_000_000);
    wait_idle();

    // binary, full 32 digits
    write_reg(rac_pkg::REG_RADIX, 32'd2);
    send_value(32'd0);
    send_value(32'd1);
    send_value(32'hFFFF_FFFF);
    send_value(32'h8000_0000);
    wait_idle();

    // hex with custom symbols, upper radix bits dropped, write to unused index
    write_reg(rac_pkg::REG_RADIX, 32'hFFFF_FFF0);
    write_reg(rac_pkg::REG_SYM_0_3, 32'h00FF_A55A);
    write_reg(rac_pkg::REG_SYM_4_7, 32'hFFFF_FFFF);
    write_reg(rac_pkg::REG_SYM_8_11, 32'h0000_0000);
    write_reg(rac_pkg::REG_SYM_12_15, 32'h1248_8421);
    write_reg(REG_UNUSED, 32'hFFFF_FFFF);
    send_value(32'hFEDC_BA98);
    send_value(32'h7654_3210);
    send_value(32'd0);
    wait_idle();

    // radix saturation below and above the legal range, then radix 3
    write_reg(rac_pkg::REG_RADIX, 32'd0);
    send_value(32'd5);
    wait_idle();
    write_reg(rac_pkg::REG_RADIX, 32'd1);
    send_value(32'd6);
    wait_idle();
    write_reg(rac_pkg::REG_RADIX, 32'd31);
    send_value(32'hABCD_EF01);
    wait_idle();
    write_reg(rac_pkg::REG_RADIX, 32'd17);
    send_value(32'h1234_5678);
    wait_idle();
    write_reg(rac_pkg::REG_RADIX, 32'd3);
    send_value(32'hFFFF_FFFF);
    wait_idle();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       radix_pick = 5'd2;
        1:       radix_pick = 5'd16;
        2:       radix_pick = 5'd10;
        3:       radix_pick = 5'd7;
        4:       radix_pick = 5'd31;
        5:       radix_pick = 5'd1;
        6:       radix_pick = 5'd3;
        default: radix_pick = 5'($urandom_range(0, 31));
      endcase
      write_reg(rac_pkg::REG_RADIX,
                {$urandom_range(0, 1) ? 27'h7FF_FFFF : 27'($urandom), radix_pick});
      if (p == 2) begin
        write_reg(rac_pkg::REG_SYM_0_3, rac_pkg::SYM_0_3_RST);
        write_reg(rac_pkg::REG_SYM_4_7, rac_pkg::SYM_4_7_RST);
        write_reg(rac_pkg::REG_SYM_8_11, rac_pkg::SYM_8_11_RST);
        write_reg(rac_pkg::REG_SYM_12_15, rac_pkg::SYM_12_15_RST);
      end else begin
        write_reg(rac_pkg::REG_SYM_0_3, $urandom);
        write_reg(rac_pkg::REG_SYM_4_7, $urandom);
        write_reg(rac_pkg::REG_SYM_8_11, $urandom);
        write_reg(rac_pkg::REG_SYM_12_15, $urandom);
      end
      idle_on = (p % 3 != 1);
      if (p == 3) hold_cycles = 400;
      for (int i = 0; i < PHASE_WORDS; i++) send_value(random_value());
      wait_idle();
    end

    if (fail_count == 0 && words_pending == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
